// ----- hdl/usbcr_pkg.sv -----
// Shared types, codes and descriptor tables of the USB control request responder.
package usbcr_pkg;

  // Event codes on the input channel
  localparam logic [1:0] ACT_SETUP = 2'd0;
  localparam logic [1:0] ACT_IN    = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_STALL = 2'd3;

  // Standard request codes
  localparam logic [7:0] REQ_ADDR_ASSIGN = 8'd5;
  localparam logic [7:0] REQ_DESC_FETCH  = 8'd6;
  localparam logic [7:0] REQ_CFG_SELECT  = 8'd9;
  localparam logic [7:0] REQ_ALT_SELECT  = 8'd11;

  // Recipient codes (low five bits of bmRequestType)
  localparam logic [4:0] RCPT_DEVICE    = 5'd0;
  localparam logic [4:0] RCPT_INTERFACE = 5'd1;

  // Interface numbers handled here
  localparam logic [7:0] IFACE_CTRL = 8'd0;
  localparam logic [7:0] IFACE_DATA = 8'd1;

  // Descriptor directory
  localparam int TABLE_SLOTS = 16;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] index;
    logic [7:0]  start;
    logic [7:0]  length;
  } desc_slot_t;

  localparam desc_slot_t DESC_TABLE [TABLE_SLOTS] = '{
    '{16'h0100, 16'h0000, 8'd0,  8'd18},
    '{16'h0200, 16'h0000, 8'd18, 8'd32},
    '{16'h0300, 16'h0000, 8'd50, 8'd6},
    '{16'h0301, 16'h0409, 8'd56, 8'd22},
    '{16'h0302, 16'h0409, 8'd78, 8'd10},
    '{16'h0303, 16'h0409, 8'd88, 8'd4},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0},
    '{16'h0000, 16'h0000, 8'd0,  8'd0}
  };

  // Descriptor bytes; everything past the last string reads as zero
  localparam int ROM_USED  = 92;
  localparam int ROM_IDX_W = $clog2(ROM_USED);

  localparam logic [7:0] DESC_ROM [ROM_USED] = '{
    // device
    8'd18, 8'd1, 8'h10, 8'h01, 8'd0, 8'd0, 8'd0, 8'd64, 8'h76, 8'h98, 8'h89, 8'h67,
    8'h01, 8'h01, 8'd1, 8'd2, 8'd3, 8'd1,
    // configuration, interface, two endpoints
    8'd9, 8'd2, 8'd32, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd25,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h01, 8'h02, 8'd8, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h82, 8'h02, 8'd8, 8'd0, 8'd10,
    // language list
    8'd6, 8'd3, 8'h09, 8'h04, 8'd0, 8'd0,
    // string 1
    8'd22, 8'd3, 8'h53, 8'd0, 8'h61, 8'd0, 8'h6d, 8'd0, 8'h20, 8'd0, 8'h42, 8'd0,
    8'h61, 8'd0, 8'h7a, 8'd0, 8'h6c, 8'd0, 8'h65, 8'd0, 8'h79, 8'd0,
    // string 2
    8'd10, 8'd3, 8'h4f, 8'd0, 8'h76, 8'd0, 8'h65, 8'd0, 8'h6e, 8'd0,
    // string 3
    8'd4, 8'd3, 8'h31, 8'd0
  };

  // Outcome of a descriptor lookup
  typedef struct packed {
    logic       hit;
    logic [6:0] start;
    logic [7:0] total;
    logic       zlp;
  } desc_hit_t;

endpackage

// ----- hdl/usbcr_in_if.sv -----
// Event channel of the USB control request responder.
interface usbcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  request_type;
  logic [7:0]  request;
  logic [15:0] setup_value;
  logic [15:0] setup_index;
  logic [15:0] requested_length;

  modport source (
    output valid, action, request_type, request, setup_value, setup_index,
           requested_length,
    input  ready
  );

  modport sink (
    input  valid, action, request_type, request, setup_value, setup_index,
           requested_length,
    output ready
  );
endinterface

// ----- hdl/usbcr_out_if.sv -----
// Result channel of the USB control request responder.
interface usbcr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last;
  logic [6:0] device_address;
  logic [7:0] selected_config;
  logic [7:0] data_alt_setting;
  logic       data_endpoint_on;

  modport source (
    output valid, kind, data_byte, last, device_address, selected_config,
           data_alt_setting, data_endpoint_on,
    input  ready
  );

  modport sink (
    input  valid, kind, data_byte, last, device_address, selected_config,
           data_alt_setting, data_endpoint_on,
    output ready
  );
endinterface

// ----- hdl/usbcr_desc_lookup.sv -----
// Descriptor directory lookup: match, length clip and zero-length-packet decision.
module usbcr_desc_lookup #(
  parameter int ROM_ENTRIES = 6,
  parameter int MAX_PACKET  = 64
) (
  input  logic [15:0]          setup_value,
  input  logic [15:0]          setup_index,
  input  logic [15:0]          requested_length,
  output usbcr_pkg::desc_hit_t result
);
  import usbcr_pkg::*;

  localparam int MULTS = 255 / MAX_PACKET;

  logic       found;
  logic [7:0] found_start;
  logic [7:0] found_length;
  logic [7:0] total;
  logic       total_mult;

  // First matching slot wins: scan from the top so lower slots override
  always_comb begin
    found        = 1'b0;
    found_start  = '0;
    found_length = '0;
    for (int i = ROM_ENTRIES - 1; i >= 0; i--) begin
      if (DESC_TABLE[i].length != 8'd0 && DESC_TABLE[i].value == setup_value &&
          DESC_TABLE[i].index == setup_index) begin
        found        = 1'b1;
        found_start  = DESC_TABLE[i].start;
        found_length = DESC_TABLE[i].length;
      end
    end
  end

  // Clip to the host's request
  assign total = ({8'h00, found_length} > requested_length) ? requested_length[7:0]
                                                             : found_length;

  // Multiple of the packet size: compare against each constant multiple
  always_comb begin
    total_mult = (total == 8'd0);
    for (int k = 1; k <= MULTS; k++) begin
      if (total == 8'(k * MAX_PACKET)) total_mult = 1'b1;
    end
  end

  assign result.hit   = found;
  assign result.start = found_start[6:0];
  assign result.total = total;
  assign result.zlp   = ({8'h00, total} < requested_length) && total_mult;

endmodule

// ----- hdl/usb_control_request_responder.sv -----
// Top level of the USB endpoint-zero control request responder.
//
// Channel req carries one event per transaction: a setup packet, an IN packet
// completion or a bus reset. Channel rsp returns the run of results that the
// event causes: the bytes of one data packet, a zero-length acknowledge, a
// stall, or a single no-response result. The final result of a run has last
// set; every result carries the device address, configuration and interface
// alternate setting as they stand after the event.
// A single-result event goes through state ST_SINGLE into the output register. A
// data run reads the descriptor ROM through a registered port: ST_READ fetches
// the first byte, then in ST_PUSH bytes follow one per cycle while the receiver
// takes them, each next byte fetched as one leaves; a run holds at most
// MAX_PACKET bytes. req.ready rises again once the last result of the run
// sits in the output register, so the next event can enter while it waits.
// A stalled receiver holds the output register and freezes the run.
// Reset (rst, synchronous) clears the address, configuration, alternate
// setting and transfer state; a bus reset event does the same.
module usb_control_request_responder #(
  parameter int MAX_PACKET  = 64,
  parameter int ROM_BYTES   = 128,
  parameter int ROM_ENTRIES = 6
) (
  input logic         clk,
  input logic         rst,
  usbcr_in_if.sink    req,
  usbcr_out_if.source rsp
);
  import usbcr_pkg::*;

  localparam int         CNT_W    = $clog2(MAX_PACKET + 1);
  localparam logic [7:0] MAX_PKT8 = 8'(MAX_PACKET);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SINGLE = 4'b0010,
    ST_READ   = 4'b0100,
    ST_PUSH   = 4'b1000
  } state_t;

  state_t     state, state_next;

  // Device and transfer state
  logic [6:0] pending_address, pending_address_next;
  logic [6:0] active_address, active_address_next;
  logic [7:0] config_value, config_value_next;
  logic [7:0] alt_setting, alt_setting_next;
  logic [6:0] transfer_start, transfer_start_next;
  logic [7:0] transfer_total, transfer_total_next;
  logic [7:0] transfer_sent, transfer_sent_next;
  logic       transfer_busy, transfer_busy_next;
  logic       zlp_pending, zlp_pending_next;

  // Run of results in progress
  logic [1:0]       single_kind, single_kind_next;
  logic             run_data;
  logic [8:0]       run_pos, run_pos_next;
  logic [CNT_W-1:0] run_left, run_left_next;

  // Output register
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic [6:0] out_address;
  logic [7:0] out_config;
  logic [7:0] out_alt;

  logic       accept;
  logic       slot_free;
  logic       load_single;
  logic       load_data;
  logic       rd_en;
  logic [8:0] rd_addr;
  logic [7:0] rom_q;

  logic [4:0] recipient;
  logic [7:0] chunk_rem;
  logic [7:0] chunk_cnt;
  logic [7:0] sent_plus;
  desc_hit_t  lk;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign slot_free = !out_valid || rsp.ready;
  assign recipient = req.request_type[4:0];

  usbcr_desc_lookup #(
    .ROM_ENTRIES (ROM_ENTRIES),
    .MAX_PACKET  (MAX_PACKET)
  ) u_lookup (
    .setup_value      (req.setup_value),
    .setup_index      (req.setup_index),
    .requested_length (req.requested_length),
    .result           (lk)
  );

  // Size of the next packet: at most one full packet of what is left
  assign chunk_rem = (req.action == ACT_SETUP) ? lk.total : (transfer_total - transfer_sent);
  assign chunk_cnt = (chunk_rem > MAX_PKT8) ? MAX_PKT8 : chunk_rem;
  assign sent_plus = transfer_sent + chunk_cnt;

  // Event decode: state update and the run that answers it
  always_comb begin
    pending_address_next = pending_address;
    active_address_next  = active_address;
    config_value_next    = config_value;
    alt_setting_next     = alt_setting;
    transfer_start_next  = transfer_start;
    transfer_total_next  = transfer_total;
    transfer_sent_next   = transfer_sent;
    transfer_busy_next   = transfer_busy;
    zlp_pending_next     = zlp_pending;
    single_kind_next     = KIND_NONE;
    run_data             = 1'b0;
    run_pos_next         = run_pos;
    run_left_next        = run_left;
    unique case (req.action)
      ACT_SETUP: begin
        transfer_busy_next = 1'b0;
        zlp_pending_next   = 1'b0;
        single_kind_next   = KIND_ACK;
        priority if (recipient == RCPT_DEVICE) begin
          priority if (req.request == REQ_DESC_FETCH) begin
            if (!lk.hit) begin
              single_kind_next = KIND_STALL;
            end else begin
              transfer_start_next = lk.start;
              transfer_total_next = lk.total;
              transfer_sent_next  = '0;
              if (lk.total != 8'd0) begin
                zlp_pending_next   = lk.zlp;
                transfer_sent_next = chunk_cnt;
                transfer_busy_next = (chunk_cnt < lk.total) || lk.zlp;
                run_data           = 1'b1;
                run_pos_next       = {2'b00, lk.start};
                run_left_next      = chunk_cnt[CNT_W-1:0];
              end
            end
          end else if (req.request == REQ_ADDR_ASSIGN) begin
            pending_address_next = req.setup_value[6:0];
          end else if (req.request == REQ_CFG_SELECT) begin
            config_value_next = req.setup_value[7:0];
          end else begin
          end
        end else if (recipient == RCPT_INTERFACE) begin
          priority if (req.setup_index[7:0] == IFACE_DATA) begin
            if (req.request == REQ_ALT_SELECT) alt_setting_next = req.setup_value[7:0];
          end else if (req.setup_index[7:0] == IFACE_CTRL) begin
          end else begin
            single_kind_next = KIND_NONE;
          end
        end else begin
        end
      end
      ACT_IN: begin
        if (transfer_busy) begin
          priority if (transfer_sent < transfer_total) begin
            transfer_sent_next = sent_plus;
            transfer_busy_next = !((sent_plus >= transfer_total) && !zlp_pending);
            run_data           = 1'b1;
            run_pos_next       = {2'b00, transfer_start} + {1'b0, transfer_sent};
            run_left_next      = chunk_cnt[CNT_W-1:0];
          end else if (zlp_pending) begin
            single_kind_next   = KIND_ACK;
            zlp_pending_next   = 1'b0;
            transfer_busy_next = 1'b0;
          end else begin
            transfer_busy_next = 1'b0;
          end
        end
        if (pending_address != 7'd0) begin
          active_address_next  = pending_address;
          pending_address_next = '0;
        end
      end
      ACT_RESET: begin
        pending_address_next = '0;
        active_address_next  = '0;
        config_value_next    = '0;
        alt_setting_next     = '0;
        transfer_start_next  = '0;
        transfer_total_next  = '0;
        transfer_sent_next   = '0;
        transfer_busy_next   = 1'b0;
        zlp_pending_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Run sequencer
  assign load_single = (state == ST_SINGLE) && slot_free;
  assign load_data   = (state == ST_PUSH) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = run_data ? ST_READ : ST_SINGLE;
      ST_SINGLE: if (slot_free) state_next = ST_IDLE;
      ST_READ:   state_next = ST_PUSH;
      ST_PUSH:   if (slot_free && run_left == CNT_W'(1)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      pending_address <= '0;
      active_address  <= '0;
      config_value    <= '0;
      alt_setting     <= '0;
      transfer_start  <= '0;
      transfer_total  <= '0;
      transfer_sent   <= '0;
      transfer_busy   <= 1'b0;
      zlp_pending     <= 1'b0;
      run_left        <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        pending_address <= pending_address_next;
        active_address  <= active_address_next;
        config_value    <= config_value_next;
        alt_setting     <= alt_setting_next;
        transfer_start  <= transfer_start_next;
        transfer_total  <= transfer_total_next;
        transfer_sent   <= transfer_sent_next;
        transfer_busy   <= transfer_busy_next;
        zlp_pending     <= zlp_pending_next;
        run_left        <= run_left_next;
      end else if (load_data) begin
        run_left <= run_left - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      single_kind <= single_kind_next;
      run_pos     <= run_pos_next;
    end else if (load_data) begin
      run_pos <= run_pos + 9'd1;
    end
  end

  // Descriptor ROM, registered read; the next byte is fetched as one leaves
  assign rd_en   = (state == ST_READ) || load_data;
  assign rd_addr = (state == ST_READ) ? run_pos : (run_pos + 9'd1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_addr < 9'(ROM_BYTES) && rd_addr < 9'(ROM_USED)) begin
        rom_q <= DESC_ROM[rd_addr[ROM_IDX_W-1:0]];
      end else begin
        rom_q <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_single || load_data) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_single || load_data) begin
      out_kind    <= load_data ? KIND_DATA : single_kind;
      out_byte    <= load_data ? rom_q : 8'h00;
      out_last    <= load_single || (run_left == CNT_W'(1));
      out_address <= active_address;
      out_config  <= config_value;
      out_alt     <= alt_setting;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.kind             = out_kind;
  assign rsp.data_byte        = out_byte;
  assign rsp.last             = out_last;
  assign rsp.device_address   = out_address;
  assign rsp.selected_config  = out_config;
  assign rsp.data_alt_setting = out_alt;
  assign rsp.data_endpoint_on = (out_alt != 8'h00);

`ifndef SYNTHESIS
  // A packet run never starts or continues with nothing left to send
  a_push_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH || state == ST_READ) |-> (run_left != '0))
    else $error("data run with zero bytes left");

  // Transfer bookkeeping stays consistent
  a_sent_le_total: assert property (@(posedge clk) disable iff (rst)
    transfer_sent <= transfer_total)
    else $error("transfer_sent beyond transfer_total");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    transfer_busy |-> (transfer_total != 8'd0))
    else $error("busy transfer with zero length");

  // Every accepted event starts a run
  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != ST_IDLE))
    else $error("accepted transaction produced no run");
`endif

endmodule

// ----- tb/sv/usb_control_request_responder_tb.sv -----
// Testbench for the USB endpoint-zero control request responder: directed and random events.
`timescale 1ns / 1ps

module usb_control_request_responder_tb;
  import usbcr_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PKT_BYTES  = 64;
  localparam int ROM_LIMIT  = 128;
  localparam int DIR_SLOTS  = 6;
  localparam int DESC_BYTES = 92;
  localparam int RANDOM_EVENTS = 480;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  request_type;
    logic [7:0]  request;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
  } ep0_event_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic [6:0] addr;
    logic [7:0] cfg;
    logic [7:0] alt;
    logic       ep_on;
  } ep0_reply_t;

  // Descriptor directory and contents as the device presents them
  localparam desc_slot_t descr_dir [DIR_SLOTS] = '{
    '{16'h0100, 16'h0000, 8'd0,  8'd18},
    '{16'h0200, 16'h0000, 8'd18, 8'd32},
    '{16'h0300, 16'h0000, 8'd50, 8'd6},
    '{16'h0301, 16'h0409, 8'd56, 8'd22},
    '{16'h0302, 16'h0409, 8'd78, 8'd10},
    '{16'h0303, 16'h0409, 8'd88, 8'd4}
  };

  localparam logic [7:0] descr_bytes [DESC_BYTES] = '{
    8'd18, 8'd1, 8'h10, 8'h01, 8'd0, 8'd0, 8'd0, 8'd64, 8'h76, 8'h98, 8'h89, 8'h67,
    8'h01, 8'h01, 8'd1, 8'd2, 8'd3, 8'd1,
    8'd9, 8'd2, 8'd32, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd25,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h01, 8'h02, 8'd8, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h82, 8'h02, 8'd8, 8'd0, 8'd10,
    8'd6, 8'd3, 8'h09, 8'h04, 8'd0, 8'd0,
    8'd22, 8'd3, 8'h53, 8'd0, 8'h61, 8'd0, 8'h6d, 8'd0, 8'h20, 8'd0, 8'h42, 8'd0,
    8'h61, 8'd0, 8'h7a, 8'd0, 8'h6c, 8'd0, 8'h65, 8'd0, 8'h79, 8'd0,
    8'd10, 8'd3, 8'h4f, 8'd0, 8'h76, 8'd0, 8'h65, 8'd0, 8'h6e, 8'd0,
    8'd4, 8'd3, 8'h31, 8'd0
  };

  logic clk = 1'b0;
  logic rst;
  logic steady = 1'b0;   // when set, neither side idles
  int   n_fail = 0;

  usbcr_in_if  req_if ();
  usbcr_out_if rsp_if ();

  usb_control_request_responder DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #10 clk = ~clk;

  // Mirror of the endpoint state
  logic [6:0] m_pend_addr, m_addr;
  logic [7:0] m_cfg, m_alt;
  logic [6:0] x_start;
  logic [7:0] x_total, x_sent;
  logic       x_busy, x_zlp;

  ep0_reply_t run_q [$];         // results of the event being predicted
  ep0_reply_t replies_due [$];   // results still to come from the DUT

  function automatic void clear_ep0_state();
    m_pend_addr = '0;
    m_addr      = '0;
    m_cfg       = '0;
    m_alt       = '0;
    x_start     = '0;
    x_total     = '0;
    x_sent      = '0;
    x_busy      = 1'b0;
    x_zlp       = 1'b0;
  endfunction

  function automatic logic [7:0] descr_byte_at(int unsigned pos);
    if (pos >= ROM_LIMIT || pos >= DESC_BYTES) return 8'h00;
    return descr_bytes[pos];
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [7:0] data);
    ep0_reply_t r;
    r = '0;
    r.kind = kind;
    r.data_byte = data;
    if (run_q.size() < PKT_BYTES) run_q.push_back(r);
  endfunction

  // One packet of the current descriptor transfer
  function automatic void send_chunk();
    int unsigned cnt;
    cnt = (x_sent > x_total) ? 0 : x_total - x_sent;
    if (cnt > PKT_BYTES) cnt = PKT_BYTES;
    for (int unsigned i = 0; i < cnt; i++)
      push_result(KIND_DATA, descr_byte_at(x_start + x_sent + i));
    x_sent = x_sent + 8'(cnt);
    if (x_sent >= x_total && !x_zlp) x_busy = 1'b0;
  endfunction

  function automatic void read_descriptor(ep0_event_t ev);
    int hit;
    int unsigned total;
    hit = -1;
    for (int i = 0; i < DIR_SLOTS; i++) begin
      if (hit < 0 && descr_dir[i].length != 0 && descr_dir[i].value == ev.value &&
          descr_dir[i].index == ev.index)
        hit = i;
    end
    if (hit < 0) begin
      push_result(KIND_STALL, 8'h00);
      return;
    end
    total = 32'(descr_dir[hit].length);
    if (total > ev.length) total = 32'(ev.length);
    x_start = descr_dir[hit].start[6:0];
    x_total = 8'(total);
    x_sent  = '0;
    if (total == 0) begin
      push_result(KIND_ACK, 8'h00);
      return;
    end
    // zero-length packet closes a transfer of whole packets shorter than asked
    x_zlp  = (total < ev.length) && (total % PKT_BYTES == 0);
    x_busy = 1'b1;
    send_chunk();
  endfunction

  function automatic void decode_setup(ep0_event_t ev);
    logic [4:0] rcpt;
    rcpt = ev.request_type[4:0];
    x_busy = 1'b0;
    x_zlp  = 1'b0;
    if (rcpt == RCPT_DEVICE) begin
      if (ev.request == REQ_DESC_FETCH) begin
        read_descriptor(ev);
        return;
      end
      if (ev.request == REQ_ADDR_ASSIGN) m_pend_addr = ev.value[6:0];
      else if (ev.request == REQ_CFG_SELECT) m_cfg = ev.value[7:0];
      push_result(KIND_ACK, 8'h00);
    end else if (rcpt == RCPT_INTERFACE) begin
      if (ev.index[7:0] == IFACE_DATA) begin
        if (ev.request == REQ_ALT_SELECT) m_alt = ev.value[7:0];
        push_result(KIND_ACK, 8'h00);
      end else if (ev.index[7:0] == IFACE_CTRL) begin
        push_result(KIND_ACK, 8'h00);
      end
    end else begin
      push_result(KIND_ACK, 8'h00);
    end
  endfunction

  // Work out the results of one accepted event and queue them
  function automatic void predict_ep0_reply(ep0_event_t ev);
    ep0_reply_t r;
    run_q.delete();
    case (ev.action)
      ACT_SETUP: decode_setup(ev);
      ACT_IN: begin
        if (x_busy) begin
          if (x_sent < x_total) begin
            send_chunk();
          end else if (x_zlp) begin
            push_result(KIND_ACK, 8'h00);
            x_zlp  = 1'b0;
            x_busy = 1'b0;
          end else begin
            x_busy = 1'b0;
          end
        end
        // address switches over on the status stage
        if (m_pend_addr != 0) begin
          m_addr = m_pend_addr;
          m_pend_addr = '0;
        end
      end
      ACT_RESET: clear_ep0_state();
      default: ;
    endcase
    if (run_q.size() == 0) push_result(KIND_NONE, 8'h00);
    foreach (run_q[k]) begin
      r = run_q[k];
      r.last  = (k == run_q.size() - 1);
      r.addr  = m_addr;
      r.cfg   = m_cfg;
      r.alt   = m_alt;
      r.ep_on = (m_alt != 0);
      replies_due.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    ep0_reply_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result transaction: kind %0d data 0x%0h",
               rsp_if.kind, rsp_if.data_byte);
        n_fail++;
      end else begin
        want = replies_due.pop_front();
        check_field("kind", 8'(want.kind), 8'(rsp_if.kind));
        check_field("data_byte", want.data_byte, rsp_if.data_byte);
        check_field("last", 8'(want.last), 8'(rsp_if.last));
        check_field("device_address", 8'(want.addr), 8'(rsp_if.device_address));
        check_field("selected_config", want.cfg, rsp_if.selected_config);
        check_field("data_alt_setting", want.alt, rsp_if.data_alt_setting);
        check_field("data_endpoint_on", 8'(want.ep_on), 8'(rsp_if.data_endpoint_on));
      end
    end
  end

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // Receiver back-pressure
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        stall = idle_len() - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Drive one event and wait for its transaction
  task automatic send_event(ep0_event_t ev);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid            <= 1'b1;
    req_if.action           <= ev.action;
    req_if.request_type     <= ev.request_type;
    req_if.request          <= ev.request;
    req_if.setup_value      <= ev.value;
    req_if.setup_index      <= ev.index;
    req_if.requested_length <= ev.length;
    do @(posedge clk); while (!req_if.ready);
    predict_ep0_reply(ev);
  endtask

  task automatic wait_drained();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic ep0_event_t mk_ev(logic [1:0] action, logic [7:0] rt, logic [7:0] rq,
                                       logic [15:0] val, logic [15:0] idx,
                                       logic [15:0] len);
    mk_ev = '{action, rt, rq, val, idx, len};
  endfunction

  task automatic test_descriptor_reads();
    send_event(mk_ev(ACT_SETUP, 8'h80, REQ_DESC_FETCH, 16'h0100, 16'h0000, 16'hFFFF));
    send_event(mk_ev(ACT_SETUP, 8'h80, REQ_DESC_FETCH, 16'h0200, 16'h0000, 16'd9));
    send_event(mk_ev(ACT_SETUP, 8'h80, REQ_DESC_FETCH, 16'h0301, 16'h0409, 16'd0));
    send_event(mk_ev(ACT_SETUP, 8'h80, REQ_DESC_FETCH, 16'h0303, 16'h0409, 16'd4));
    // wrong language id: miss
    send_event(mk_ev(ACT_SETUP, 8'h80, REQ_DESC_FETCH, 16'h0302, 16'h0000, 16'd64));
    send_event(mk_ev(ACT_SETUP, 8'h80, REQ_DESC_FETCH, 16'h0300, 16'h0000, 16'd1));
    send_event(mk_ev(ACT_IN, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_address_assignment();
    send_event(mk_ev(ACT_SETUP, 8'h00, REQ_ADDR_ASSIGN, 16'hFFFF, 16'h0000, 16'h0000));
    send_event(mk_ev(ACT_IN, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // address zero keeps the active address
    send_event(mk_ev(ACT_SETUP, 8'h00, REQ_ADDR_ASSIGN, 16'h0000, 16'h0000, 16'h0000));
    send_event(mk_ev(ACT_IN, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_config_and_interface();
    send_event(mk_ev(ACT_SETUP, 8'h00, REQ_CFG_SELECT, 16'hFFFF, 16'h0000, 16'h0));
    send_event(mk_ev(ACT_SETUP, 8'h01, REQ_ALT_SELECT, 16'h00AB, 16'hFF01, 16'h0000));
    send_event(mk_ev(ACT_SETUP, 8'h01, REQ_ALT_SELECT, 16'h0007, 16'h0000, 16'h0000));
    // unknown interface gives no response
    send_event(mk_ev(ACT_SETUP, 8'h01, 8'h00, 16'h0000, 16'h0002, 16'h0000));
    send_event(mk_ev(ACT_SETUP, 8'h21, 8'h0A, 16'h0000, 16'h0101, 16'h0000));
    send_event(mk_ev(ACT_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_event(mk_ev(ACT_SETUP, 8'h02, REQ_DESC_FETCH, 16'h0100, 16'h0000, 16'd18));
  endtask

  task automatic test_misc_events();
    // setup right behind a descriptor transfer that fits in one packet
    send_event(mk_ev(ACT_SETUP, 8'h80, REQ_DESC_FETCH, 16'h0200, 16'h0000, 16'hFFFF));
    send_event(mk_ev(ACT_SETUP, 8'h00, REQ_CFG_SELECT, 16'h0001, 16'h0000, 16'h0));
    send_event(mk_ev(ACT_IN, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
    send_event(mk_ev(ACT_UNUSED, 8'h00, REQ_ADDR_ASSIGN, 16'h0011, 16'h0000, 16'h0000));
    send_event(mk_ev(ACT_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
    send_event(mk_ev(ACT_IN, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
  endtask

  function automatic ep0_event_t random_event();
    ep0_event_t ev;
    int unsigned pick, slot;
    ev = '{ACT_SETUP, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom)};
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, DIR_SLOTS - 1);
    if (pick < 35) begin
      ev.request_type = {ev.request_type[7:5], RCPT_DEVICE};
      ev.request = REQ_DESC_FETCH;
      if ($urandom_range(0, 7) != 0) begin
        ev.value = descr_dir[slot].value;
        ev.index = descr_dir[slot].index;
      end
      case ($urandom_range(0, 4))
        0: ev.length = 16'($urandom_range(0, 3));
        1: ev.length = 16'($urandom_range(0, 40));
        2: ev.length = {8'h00, descr_dir[slot].length};
        3: ev.length = 16'hFFFF;
        default: ;
      endcase
    end else if (pick < 55) begin
      ev.action = ACT_IN;
    end else if (pick < 65) begin
      ev.request_type = {ev.request_type[7:5], RCPT_DEVICE};
      ev.request = REQ_ADDR_ASSIGN;
    end else if (pick < 73) begin
      ev.request_type = {ev.request_type[7:5], RCPT_DEVICE};
      ev.request = REQ_CFG_SELECT;
    end else if (pick < 87) begin
      ev.request_type = {ev.request_type[7:5], RCPT_INTERFACE};
      if ($urandom_range(0, 9) < 7) ev.request = REQ_ALT_SELECT;
      case ($urandom_range(0, 3))
        0, 1: ev.index[7:0] = IFACE_DATA;
        2: ev.index[7:0] = IFACE_CTRL;
        default: ;
      endcase
      if ($urandom_range(0, 2) == 0) ev.value[7:0] = 8'h00;
    end else if (pick < 92) begin
      ev.action = ACT_RESET;
    end else if (pick < 94) begin
      ev.action = ACT_UNUSED;
    end
    return ev;
  endfunction

  task automatic test_random_traffic();
    for (int k = 0; k < RANDOM_EVENTS; k++) begin
      steady <= ((k % 100) >= 75);
      // hold off once until the DUT has answered everything
      if (k == RANDOM_EVENTS / 2) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      send_event(random_event());
    end
    steady <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    req_if.valid            <= 1'b0;
    req_if.action           <= ACT_SETUP;
    req_if.request_type     <= '0;
    req_if.request          <= '0;
    req_if.setup_value      <= '0;
    req_if.setup_index      <= '0;
    req_if.requested_length <= '0;
    clear_ep0_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_descriptor_reads();
    test_address_assignment();
    test_config_and_interface();
    test_misc_events();
    test_random_traffic();

    // drain, then watch for stray results
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (80) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d expected results never arrived", replies_due.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- usb_control_request_responder.f -----
hdl/usbcr_pkg.sv
hdl/usbcr_in_if.sv
hdl/usbcr_out_if.sv
hdl/usbcr_desc_lookup.sv
hdl/usb_control_request_responder.sv
tb/sv/usb_control_request_responder_tb.sv
